// ===== rtl/svpc_pkg.sv =====
// ----------------------------------------------------------------------------
// svpc_pkg
// Shared widths, register indexes, reset values and the square root stage
// count for the velocity command unit.
// ----------------------------------------------------------------------------
package svpc_pkg;

	localparam int ACC_W  = 24;
	localparam int VEL_W  = 23;
	localparam int TOL_W  = 23;
	localparam int ATOL_W = 19;
	localparam int YAW_W  = 20;
	localparam int OUT_W  = 24;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ACCEL_LIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_ACCEL_ANG = 3'd1;
	localparam logic [IDX_W-1:0] REG_VMAX_LIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_VMIN_LIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_VMAX_ANG  = 3'd4;
	localparam logic [IDX_W-1:0] REG_VMIN_ANG  = 3'd5;
	localparam logic [IDX_W-1:0] REG_TOL_LIN   = 3'd6;
	localparam logic [IDX_W-1:0] REG_TOL_ANG   = 3'd7;

	localparam logic [ACC_W-1:0]  RST_ACCEL_LIN = 24'd32768;
	localparam logic [ACC_W-1:0]  RST_ACCEL_ANG = 24'd65536;
	localparam logic [VEL_W-1:0]  RST_VMAX_LIN  = 23'd32768;
	localparam logic [VEL_W-1:0]  RST_VMIN_LIN  = 23'd3277;
	localparam logic [VEL_W-1:0]  RST_VMAX_ANG  = 23'd65536;
	localparam logic [VEL_W-1:0]  RST_VMIN_ANG  = 23'd6554;
	localparam logic [TOL_W-1:0]  RST_TOL_LIN   = 23'd655;
	localparam logic [ATOL_W-1:0] RST_TOL_ANG   = 19'd3277;

	// two root bits per stage
	function automatic int sqrt_stages(int rad_w);
		return (rad_w + 3) / 4;
	endfunction

endpackage

// ===== rtl/svpc_sqrt.sv =====
// ----------------------------------------------------------------------------
// svpc_sqrt
// Pipelined restoring integer square root, two root bits per stage, with a
// sideband that travels alongside the data.
// ----------------------------------------------------------------------------
module svpc_sqrt #(
	parameter int RAD_W  = 49,
	parameter int SIDE_W = 2,
	localparam int NS     = svpc_pkg::sqrt_stages(RAD_W),
	localparam int ROOT_W = 2 * NS
) (
	input  logic              clk,
	input  logic [RAD_W-1:0]  rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);
	import svpc_pkg::*;

	localparam int PAD_W = 4 * NS;
	localparam int REM_W = ROOT_W + 2;

	logic [PAD_W-1:0]  rad_s  [1:NS-1];
	logic [REM_W-1:0]  rem_s  [1:NS];
	logic [ROOT_W-1:0] root_s [1:NS];
	logic [SIDE_W-1:0] side_s [1:NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [PAD_W-1:0]  rad_i;
		logic [REM_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		logic [SIDE_W-1:0] side_i;
		logic [REM_W-1:0]  rem_n;
		logic [ROOT_W-1:0] root_n;

		if (k == 0) begin : g_first
			assign rad_i  = PAD_W'(rad);
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign rad_i  = rad_s[k];
			assign rem_i  = rem_s[k];
			assign root_i = root_s[k];
			assign side_i = side_s[k];
		end

		always_comb begin
			logic [REM_W+1:0]  sh_v;
			logic [REM_W+1:0]  tr_v;
			logic [REM_W+1:0]  df_v;
			logic [REM_W-1:0]  rem_v;
			logic [ROOT_W-1:0] root_v;
			rem_v  = rem_i;
			root_v = root_i;
			for (int j = 0; j < 2; j++) begin
				sh_v = {rem_v, rad_i[PAD_W-1-2*j -: 2]};
				tr_v = {2'b00, root_v, 2'b01};
				df_v = sh_v - tr_v;
				if (sh_v >= tr_v) begin
					rem_v  = df_v[REM_W-1:0];
					root_v = {root_v[ROOT_W-2:0], 1'b1};
				end else begin
					rem_v  = sh_v[REM_W-1:0];
					root_v = {root_v[ROOT_W-2:0], 1'b0};
				end
			end
			rem_n  = rem_v;
			root_n = root_v;
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= rem_n;
			root_s[k+1] <= root_n;
			side_s[k+1] <= side_i;
		end

		if (k < NS - 1) begin : g_rad
			always_ff @(posedge clk) begin
				rad_s[k+1] <= {rad_i[PAD_W-5:0], 4'b0000};
			end
		end
	end

	assign root     = root_s[NS];
	assign side_out = side_s[NS];

endmodule

// ===== rtl/svpc_axis.sv =====
// ----------------------------------------------------------------------------
// svpc_axis
// One axis of the velocity command: 2*accel*|e|, square root, clamp to the
// max/min speed, then the sign of the error.
// ----------------------------------------------------------------------------
module svpc_axis #(
	parameter int MAG_W = 24
) (
	input  logic                           clk,
	input  logic [MAG_W-1:0]               mag,
	input  logic                           neg,
	input  logic [svpc_pkg::ACC_W-1:0]     accel,
	input  logic [svpc_pkg::VEL_W-1:0]     vmax,
	input  logic [svpc_pkg::VEL_W-1:0]     vmin,
	output logic signed [svpc_pkg::OUT_W-1:0] vel
);
	import svpc_pkg::*;

	localparam int PROD_W = MAG_W + ACC_W;
	localparam int RAD_W  = PROD_W + 1;
	localparam int ROOT_W = 2 * sqrt_stages(RAD_W);

	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1;
	logic              zero_s1;
	logic [ROOT_W-1:0] root;
	logic [1:0]        side_o;
	logic [VEL_W-1:0]  mag_c;
	logic [OUT_W-1:0]  vel_n;
	logic [OUT_W-1:0]  vel_q;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(accel) * PROD_W'(mag);
		neg_s1  <= neg;
		zero_s1 <= (mag == '0);
	end

	svpc_sqrt #(
		.RAD_W  (RAD_W),
		.SIDE_W (2)
	) u_sqrt (
		.clk      (clk),
		.rad      ({prod_s1, 1'b0}),
		.side_in  ({neg_s1, zero_s1}),
		.root     (root),
		.side_out (side_o)
	);

	// max test wins over min test when the two overlap
	always_comb begin
		if (side_o[0]) begin
			mag_c = '0;
		end else if (root > ROOT_W'(vmax)) begin
			mag_c = vmax;
		end else if (root < ROOT_W'(vmin)) begin
			mag_c = vmin;
		end else begin
			mag_c = root[VEL_W-1:0];
		end
		vel_n = side_o[1] ? (OUT_W'(0) - OUT_W'(mag_c)) : OUT_W'(mag_c);
	end

	always_ff @(posedge clk) begin
		vel_q <= vel_n;
	end

	assign vel = $signed(vel_q);

endmodule

// ===== rtl/sqrt_profile_velocity_command_unit.sv =====
// ----------------------------------------------------------------------------
// sqrt_profile_velocity_command_unit
// Square-root deceleration velocity command with an arrival test.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low. busy stays low:
//   the pipeline takes a new set of errors (err_x, err_y, err_yaw) in every
//   cycle. Each transaction gives one result on vel_x, vel_y, vel_yaw and
//   arrived, shown for exactly one cycle with done high.
//   The result goes through the magnitude stage, the multiply stage, the
//   square root pipeline, which resolves two root bits per stage, and the
//   clamp and output stages; the magnitude, multiply, clamp and output
//   stages add one register each.
//   Throughput is one transaction per cycle.
//   Configuration is a plain write port (cfg_wr_en, cfg_addr, cfg_wdata); the
//   user writes it only while no transaction is in flight; the block never checks.
//   Reset loads the default limits and empties the pipeline; transactions
//   in flight are dropped. The receiver cannot stall, so there is no
//   backpressure path.
// ----------------------------------------------------------------------------
module sqrt_profile_velocity_command_unit #(
	parameter int ERR_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [ERR_WIDTH-1:0]         err_x,
	input  logic signed [ERR_WIDTH-1:0]         err_y,
	input  logic signed [svpc_pkg::YAW_W-1:0]   err_yaw,
	output logic                                done,
	output logic signed [svpc_pkg::OUT_W-1:0]   vel_x,
	output logic signed [svpc_pkg::OUT_W-1:0]   vel_y,
	output logic signed [svpc_pkg::OUT_W-1:0]   vel_yaw,
	output logic                                arrived,
	input  logic                                cfg_wr_en,
	input  logic [svpc_pkg::IDX_W-1:0]          cfg_addr,
	input  logic [svpc_pkg::CFG_W-1:0]          cfg_wdata
);
	import svpc_pkg::*;

	localparam int MAG_W = (ERR_WIDTH > YAW_W) ? ERR_WIDTH : YAW_W;
	localparam int NS    = sqrt_stages(MAG_W + ACC_W + 1);
	localparam int LAT   = NS + 4;
	localparam int SQ_W  = 2 * ERR_WIDTH;
	localparam int DW    = (SQ_W + 1 > 2 * TOL_W) ? SQ_W + 1 : 2 * TOL_W;

	// configuration
	logic [ACC_W-1:0]  accel_lin_q;
	logic [ACC_W-1:0]  accel_ang_q;
	logic [VEL_W-1:0]  vmax_lin_q;
	logic [VEL_W-1:0]  vmin_lin_q;
	logic [VEL_W-1:0]  vmax_ang_q;
	logic [VEL_W-1:0]  vmin_ang_q;
	logic [TOL_W-1:0]  tol_lin_q;
	logic [ATOL_W-1:0] tol_ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_lin_q <= RST_ACCEL_LIN;
			accel_ang_q <= RST_ACCEL_ANG;
			vmax_lin_q  <= RST_VMAX_LIN;
			vmin_lin_q  <= RST_VMIN_LIN;
			vmax_ang_q  <= RST_VMAX_ANG;
			vmin_ang_q  <= RST_VMIN_ANG;
			tol_lin_q   <= RST_TOL_LIN;
			tol_ang_q   <= RST_TOL_ANG;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_ACCEL_LIN: accel_lin_q <= cfg_wdata[ACC_W-1:0];
				REG_ACCEL_ANG: accel_ang_q <= cfg_wdata[ACC_W-1:0];
				REG_VMAX_LIN:  vmax_lin_q  <= cfg_wdata[VEL_W-1:0];
				REG_VMIN_LIN:  vmin_lin_q  <= cfg_wdata[VEL_W-1:0];
				REG_VMAX_ANG:  vmax_ang_q  <= cfg_wdata[VEL_W-1:0];
				REG_VMIN_ANG:  vmin_ang_q  <= cfg_wdata[VEL_W-1:0];
				REG_TOL_LIN:   tol_lin_q   <= cfg_wdata[TOL_W-1:0];
				REG_TOL_ANG:   tol_ang_q   <= cfg_wdata[ATOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: magnitudes; the most negative value maps to 2^(w-1)
	logic [ERR_WIDTH-1:0] abs_x;
	logic [ERR_WIDTH-1:0] abs_y;
	logic [YAW_W-1:0]     abs_yaw;

	assign abs_x   = err_x[ERR_WIDTH-1] ? (~$unsigned(err_x) + 1'b1) : $unsigned(err_x);
	assign abs_y   = err_y[ERR_WIDTH-1] ? (~$unsigned(err_y) + 1'b1) : $unsigned(err_y);
	assign abs_yaw = err_yaw[YAW_W-1] ? (~$unsigned(err_yaw) + 1'b1) : $unsigned(err_yaw);

	logic [ERR_WIDTH-1:0] absx_s1;
	logic [ERR_WIDTH-1:0] absy_s1;
	logic [YAW_W-1:0]     absyaw_s1;
	logic                 negx_s1;
	logic                 negy_s1;
	logic                 negyaw_s1;

	always_ff @(posedge clk) begin
		absx_s1   <= abs_x;
		absy_s1   <= abs_y;
		absyaw_s1 <= abs_yaw;
		negx_s1   <= err_x[ERR_WIDTH-1];
		negy_s1   <= err_y[ERR_WIDTH-1];
		negyaw_s1 <= err_yaw[YAW_W-1];
	end

	// arrival test: stage 2 squares, stage 3 sum and compare
	logic [SQ_W-1:0]    sqx_s2;
	logic [SQ_W-1:0]    sqy_s2;
	logic [2*TOL_W-1:0] tolsq_s2;
	logic               yawok_s2;
	logic [SQ_W:0]      dist_sum;
	logic               arr_s [3:NS+3];

	always_ff @(posedge clk) begin
		sqx_s2   <= SQ_W'(absx_s1) * SQ_W'(absx_s1);
		sqy_s2   <= SQ_W'(absy_s1) * SQ_W'(absy_s1);
		tolsq_s2 <= (2*TOL_W)'(tol_lin_q) * (2*TOL_W)'(tol_lin_q);
		yawok_s2 <= (absyaw_s1 <= YAW_W'(tol_ang_q));
	end

	assign dist_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		arr_s[3] <= (DW'(dist_sum) <= DW'(tolsq_s2)) && yawok_s2;
	end

	// hold the arrival flag until the axis results come out
	for (genvar i = 4; i <= NS + 3; i++) begin : g_arr
		always_ff @(posedge clk) begin
			arr_s[i] <= arr_s[i-1];
		end
	end

	// axis units
	logic signed [OUT_W-1:0] velx_ax;
	logic signed [OUT_W-1:0] vely_ax;
	logic signed [OUT_W-1:0] velyaw_ax;

	svpc_axis #(.MAG_W(MAG_W)) u_axis_x (
		.clk   (clk),
		.mag   (MAG_W'(absx_s1)),
		.neg   (negx_s1),
		.accel (accel_lin_q),
		.vmax  (vmax_lin_q),
		.vmin  (vmin_lin_q),
		.vel   (velx_ax)
	);

	svpc_axis #(.MAG_W(MAG_W)) u_axis_y (
		.clk   (clk),
		.mag   (MAG_W'(absy_s1)),
		.neg   (negy_s1),
		.accel (accel_lin_q),
		.vmax  (vmax_lin_q),
		.vmin  (vmin_lin_q),
		.vel   (vely_ax)
	);

	svpc_axis #(.MAG_W(MAG_W)) u_axis_yaw (
		.clk   (clk),
		.mag   (MAG_W'(absyaw_s1)),
		.neg   (negyaw_s1),
		.accel (accel_ang_q),
		.vmax  (vmax_ang_q),
		.vmin  (vmin_ang_q),
		.vel   (velyaw_ax)
	);

	// valid bits travel alongside the data
	logic [LAT-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[LAT-2]) begin
			vel_x   <= arr_s[NS+3] ? '0 : velx_ax;
			vel_y   <= arr_s[NS+3] ? '0 : vely_ax;
			vel_yaw <= arr_s[NS+3] ? '0 : velyaw_ax;
			arrived <= arr_s[NS+3];
		end
	end

	assign done = vld_s[LAT-1];

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a transaction accepted LAT cycles earlier");

	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && arrived |-> vel_x == '0 && vel_y == '0 && vel_yaw == '0)
		else $error("nonzero velocity on arrival");

	a_sign_x: assert property (@(posedge clk) disable iff (!arst_n)
		done && !arrived && vel_x != '0 |-> vel_x[OUT_W-1] == $past(err_x[ERR_WIDTH-1], LAT))
		else $error("x velocity sign differs from error sign");

	a_zero_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(err_yaw, LAT) == '0 |-> vel_yaw == '0)
		else $error("zero yaw error gave nonzero yaw rate");
`endif

endmodule
